// ===== rtl/edfs_pkg.sv =====
`timescale 1ns / 1ps

package edfs_pkg;

    // slot numbers carried along the cell row cover the largest task count (64)
    localparam int SLOT_W = 6;

    localparam int ACT_W  = 4;
    localparam int TIME_W = 32;
    localparam int PARM_W = 16;

    // request codes
    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [2:0]  task_slot;
        logic [15:0] exec_time;
        logic [15:0] period_ticks;
        logic [15:0] relative_deadline;
    } t_req;

    typedef struct packed {
        logic [31:0] tick_time;
        logic        busy_res;
        logic [2:0]  running_slot;
    } t_res;

    // best candidate so far, walking down the cell row
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [TIME_W-1:0] due;
        logic [SLOT_W-1:0] slot;
    } t_token;

    // per-cell control from the top level
    typedef struct packed {
        logic en;
        logic load;
        logic dec;
    } t_cell_ctl;

endpackage

// ===== rtl/edfs_cell.sv =====
`timescale 1ns / 1ps

module edfs_cell #(
    parameter int IDX = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  edfs_pkg::t_cell_ctl              i_ctl,
    input  edfs_pkg::t_req                   i_req,
    input  logic [edfs_pkg::TIME_W-1:0]      i_now,
    input  edfs_pkg::t_token                 i_tok,
    output edfs_pkg::t_token                 o_tok
);

    logic [edfs_pkg::PARM_W-1:0] r_len, r_per, r_off, r_work;
    logic [edfs_pkg::TIME_W-1:0] r_release, r_due;
    edfs_pkg::t_token            r_tok;

    logic                        rel;
    logic [edfs_pkg::PARM_W-1:0] eff_work;
    logic [edfs_pkg::TIME_W-1:0] rel_due;
    logic [edfs_pkg::TIME_W-1:0] eff_due;
    logic                        take;
    edfs_pkg::t_token            n_tok;

    always_comb begin
        rel      = i_tok.valid && i_ctl.en && (r_release == i_now);
        rel_due  = i_now + {{(edfs_pkg::TIME_W - edfs_pkg::PARM_W){1'b0}}, r_off};
        eff_work = rel ? r_len : r_work;
        eff_due  = rel ? rel_due : r_due;
        take     = i_tok.valid && i_ctl.en && (eff_work != '0)
                   && (!i_tok.found || (eff_due < i_tok.due));
        n_tok       = i_tok;
        n_tok.found = i_tok.found || take;
        if (take) begin
            n_tok.due  = eff_due;
            n_tok.slot = edfs_pkg::SLOT_W'(IDX);
        end
    end

    // task parameters: undefined until loaded
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_len <= i_req.exec_time;
            r_per <= i_req.period_ticks;
            r_off <= i_req.relative_deadline;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work    <= '0;
            r_release <= '0;
            r_due     <= '0;
        end else if (i_ctl.load) begin
            r_work    <= '0;
            r_release <= '0;
            r_due     <= '0;
        end else if (rel) begin
            r_work    <= r_len;
            r_due     <= rel_due;
            r_release <= r_release
                         + {{(edfs_pkg::TIME_W - edfs_pkg::PARM_W){1'b0}}, r_per};
        end else if (i_ctl.dec) begin
            r_work    <= r_work - edfs_pkg::PARM_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/edf_periodic_task_scheduler.sv =====
`timescale 1ns / 1ps
// earliest-deadline-first scheduler built as a row of MAX_TASKS task cells
// load item: written into its slot's cell, no result; the next item can follow at once
// tick item: the token walks down the cell row through each cell's token register, then
//   the result passes the pending stage into the output register; a new item is taken only
//   once the result has left the pending stage; output stalls delay both
// synchronous active-low reset clears time, active count, work, releases and deadlines

module edf_periodic_task_scheduler #(
    parameter int MAX_TASKS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration: active task count
    input  logic                         i_cfg_we,
    input  logic [edfs_pkg::ACT_W-1:0]   i_cfg_wdata,
    // request channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  edfs_pkg::t_req               i_req,
    // result channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output edfs_pkg::t_res               o_res
);

    logic [edfs_pkg::ACT_W-1:0]  r_active;
    logic [edfs_pkg::TIME_W-1:0] r_now;
    logic                        r_busy;     // a tick token walks the row
    logic                        r_pend_valid;
    edfs_pkg::t_res              r_pend_res;
    logic                        r_out_valid;
    edfs_pkg::t_res              r_out_res;

    logic                        acc;
    logic                        acc_tick;
    logic                        acc_load;
    logic                        done;
    logic                        pend_move;
    edfs_pkg::t_token            last_tok;

    // tok[i] feeds cell i; tok[MAX_TASKS] is the row output
    edfs_pkg::t_token            tok [MAX_TASKS+1];
    edfs_pkg::t_cell_ctl         ctl [MAX_TASKS];
    logic [MAX_TASKS-1:0]        tok_vld;

    // no item is taken while reset is held
    assign o_ready  = i_rst_n && !r_busy && !r_pend_valid;
    assign acc      = i_valid && o_ready;
    assign acc_tick = acc && (i_req.req_type == edfs_pkg::REQ_TICK);
    assign acc_load = acc && (i_req.req_type == edfs_pkg::REQ_LOAD);

    // start token enters cell 0 in the accept cycle, empty candidate
    assign tok[0] = {acc_tick, 1'b0, {edfs_pkg::TIME_W{1'b0}}, {edfs_pkg::SLOT_W{1'b0}}};

    assign last_tok = tok[MAX_TASKS];
    assign done     = last_tok.valid;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
            always_comb begin
                // slots at or above the active count sit out; counts above
                // the row length act as the row length automatically
                ctl[gi].en   = (32'(gi) < 32'(r_active));
                // slots past the row never match, so those loads drop
                ctl[gi].load = acc_load && (32'(i_req.task_slot) == 32'(gi));
                // winner of the finished walk loses one unit of work
                ctl[gi].dec  = done && last_tok.found
                               && (last_tok.slot == edfs_pkg::SLOT_W'(gi));
            end

            edfs_cell #(
                .IDX (gi)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (ctl[gi]),
                .i_req   (i_req),
                .i_now   (r_now),
                .i_tok   (tok[gi]),
                .o_tok   (tok[gi+1])
            );

            assign tok_vld[gi] = tok[gi+1].valid;
        end
    endgenerate

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    // tick control and time counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_now  <= '0;
        end else begin
            if (acc_tick) begin
                r_busy <= 1'b1;
            end else if (done) begin
                r_busy <= 1'b0;
            end
            if (done) begin
                r_now <= r_now + edfs_pkg::TIME_W'(1);
            end
        end
    end

    // pending result stage, parts the row from the output register
    assign pend_move = r_pend_valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (done) begin
            r_pend_valid <= 1'b1;
        end else if (pend_move) begin
            r_pend_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_pend_res.tick_time    <= r_now;
            r_pend_res.busy_res     <= last_tok.found;
            r_pend_res.running_slot <= last_tok.found ? last_tok.slot[2:0] : 3'd0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (pend_move) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pend_move) begin
            r_out_res <= r_pend_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out_res;

    // at most one token in the row at a time
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok_vld))
        else $error("more than one tick token in the cell row");

    // no token in the row unless a tick is in progress
    a_idle_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (tok_vld == '0))
        else $error("token in the cell row while idle");

    // a walk in progress and a waiting result never coexist
    a_busy_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_pend_valid))
        else $error("tick walk overlaps a pending result");

    // a finished walk always produces a pending result next cycle
    a_done_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> r_pend_valid)
        else $error("finished tick lost its result");

endmodule

// ===== verif/edf_periodic_task_scheduler_tb.sv =====
`timescale 1ns / 1ps

module edf_periodic_task_scheduler_tb;

    localparam int MAX_TASKS = 8;
    // extra cycles after the last report: one full walk of the cell row plus margin
    localparam int SETTLE_CYCLES = 2 * MAX_TASKS + 4;

    // dut connections; the inputs are known from time zero
    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [edfs_pkg::ACT_W-1:0]     i_cfg_wdata = '0;
    logic                           i_valid     = 1'b0;
    logic                           o_ready;
    edfs_pkg::t_req                 i_req       = '0;
    logic                           o_valid;
    logic                           i_ready     = 1'b0;
    edfs_pkg::t_res                 o_res;

    // stimulus waiting for the driver, tick reports waiting for the monitor
    edfs_pkg::t_req pending_reqs[$];
    edfs_pkg::t_res awaited_reports[$];

    // idling knobs, percent of cycles
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // scheduler state as the predictor sees it
    logic [15:0]                job_len    [MAX_TASKS];
    logic [15:0]                job_per    [MAX_TASKS];
    logic [15:0]                job_dl     [MAX_TASKS];
    logic [15:0]                work_left  [MAX_TASKS];
    logic [31:0]                release_at [MAX_TASKS];
    logic [31:0]                due_at     [MAX_TASKS];
    logic [31:0]                now_tick   = '0;
    logic [edfs_pkg::ACT_W-1:0] active_cnt = '0;

    int error_count = 0;
    int n_loads     = 0;
    int n_ticks     = 0;
    int n_busy      = 0;
    int n_idle      = 0;

    edf_periodic_task_scheduler #(
        .MAX_TASKS (MAX_TASKS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_res       (o_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor: apply one accepted item, queue the tick report it produces
    function automatic void apply_request(input edfs_pkg::t_req r);
        int             cnt;
        int             i;
        int             pick;
        edfs_pkg::t_res rep;
        if (r.req_type == edfs_pkg::REQ_LOAD) begin
            // a load rewrites the parameters and clears the job state of that slot
            job_len[r.task_slot]    = r.exec_time;
            job_per[r.task_slot]    = r.period_ticks;
            job_dl[r.task_slot]     = r.relative_deadline;
            work_left[r.task_slot]  = '0;
            release_at[r.task_slot] = '0;
            due_at[r.task_slot]     = '0;
            n_loads++;
            return;
        end
        // active counts above capacity behave as full capacity
        cnt = (active_cnt > MAX_TASKS) ? MAX_TASKS : int'(active_cnt);
        // release step
        for (i = 0; i < cnt; i++) begin
            if (release_at[i] == now_tick) begin
                work_left[i]  = job_len[i];
                due_at[i]     = now_tick + 32'(job_dl[i]);
                release_at[i] = release_at[i] + 32'(job_per[i]);
            end
        end
        // earliest deadline among ready slots, strict compare keeps the lowest slot on ties
        pick = -1;
        for (i = 0; i < cnt; i++) begin
            if (work_left[i] != 0 && (pick < 0 || due_at[i] < due_at[pick]))
                pick = i;
        end
        rep.tick_time    = now_tick;
        rep.busy_res     = (pick >= 0);
        rep.running_slot = (pick >= 0) ? 3'(pick) : 3'd0;
        if (pick >= 0)
            work_left[pick] = work_left[pick] - 16'd1;
        awaited_reports.push_back(rep);
        now_tick = now_tick + 32'd1;
        n_ticks++;
    endfunction

    // compare one accepted report against the oldest prediction
    task automatic check_report(input edfs_pkg::t_res got);
        edfs_pkg::t_res want;
        if (awaited_reports.size() == 0) begin
            $error("report with no tick pending: tick_time %0d", got.tick_time);
            error_count++;
            return;
        end
        want = awaited_reports.pop_front();
        if (got.tick_time !== want.tick_time) begin
            $error("tick_time expected %0d actual %0d", want.tick_time, got.tick_time);
            error_count++;
        end
        if (got.busy_res !== want.busy_res) begin
            $error("busy_res expected %0d actual %0d", want.busy_res, got.busy_res);
            error_count++;
        end
        if (got.running_slot !== want.running_slot) begin
            $error("running_slot expected %0d actual %0d", want.running_slot,
                   got.running_slot);
            error_count++;
        end
        if (want.busy_res) n_busy++;
        else n_idle++;
    endtask

    // driver: predict on accept, then present the next item or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                apply_request(i_req);
            // payload may only change when nothing is on offer or the item just went in
            if (!i_valid || o_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_req   <= pending_reqs.pop_front();
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check on accept, random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready)
                check_report(o_res);
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic edfs_pkg::t_req make_load(input logic [2:0] slot,
                                                 input logic [15:0] e,
                                                 input logic [15:0] p,
                                                 input logic [15:0] d);
        edfs_pkg::t_req r;
        r.req_type          = edfs_pkg::REQ_LOAD;
        r.task_slot         = slot;
        r.exec_time         = e;
        r.period_ticks      = p;
        r.relative_deadline = d;
        return r;
    endfunction

    // tick with a random payload, which the block must ignore
    function automatic edfs_pkg::t_req make_tick();
        edfs_pkg::t_req r;
        r          = make_load(3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                               16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        r.req_type = edfs_pkg::REQ_TICK;
        return r;
    endfunction

    // random mix: mostly ticks, loads only into the given slot range
    task automatic queue_random(input int n, input int load_pct, input int slot_lo,
                                input int slot_hi);
        int k;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < load_pct)
                pending_reqs.push_back(make_load(3'($urandom_range(slot_lo, slot_hi)),
                                                 16'($urandom_range(0, 65535)),
                                                 16'($urandom_range(0, 65535)),
                                                 16'($urandom_range(0, 65535))));
            else
                pending_reqs.push_back(make_tick());
        end
    endtask

    // wait until the driver has nothing left and every report has come back
    task automatic drain();
        do @(negedge i_clk);
        while (pending_reqs.size() != 0 || i_valid || awaited_reports.size() != 0);
    endtask

    // register write, only ever issued with the block idle
    task automatic set_active(input logic [edfs_pkg::ACT_W-1:0] v);
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        active_cnt   = v;
    endtask

    initial begin : main_seq
        int k;
        for (k = 0; k < MAX_TASKS; k++) begin
            job_len[k]    = '0;
            job_per[k]    = '0;
            job_dl[k]     = '0;
            work_left[k]  = '0;
            release_at[k] = '0;
            due_at[k]     = '0;
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // phase 1: count above capacity, no idling
        set_active(4'd15);
        // every slot gets parameters before the first tick, which releases them all
        pending_reqs.push_back(make_load(3'd0, 16'd2,     16'd8,     16'd8));
        pending_reqs.push_back(make_load(3'd1, 16'd2,     16'd10,    16'd5));
        // never ready, zero deadline
        pending_reqs.push_back(make_load(3'd2, 16'd0,     16'd4,     16'd0));
        // zero period, largest work and deadline: released once, runs in the gaps
        pending_reqs.push_back(make_load(3'd3, 16'hFFFF,  16'd0,     16'hFFFF));
        pending_reqs.push_back(make_load(3'd4, 16'd1,     16'd7,     16'd0));
        // slots five and six tie on deadline, the lower one must win
        pending_reqs.push_back(make_load(3'd5, 16'd1,     16'd6,     16'd3));
        pending_reqs.push_back(make_load(3'd6, 16'd1,     16'd6,     16'd3));
        // largest period
        pending_reqs.push_back(make_load(3'd7, 16'd4,     16'hFFFF,  16'd20));
        pending_reqs.push_back(edfs_pkg::t_req'{edfs_pkg::REQ_TICK, 3'd7, 16'hFFFF,
                                                16'hFFFF, 16'hFFFF});
        pending_reqs.push_back(edfs_pkg::t_req'{edfs_pkg::REQ_TICK, 3'd0, 16'h0000,
                                                16'h0000, 16'h0000});
        for (k = 0; k < 12; k++)
            pending_reqs.push_back(make_tick());
        queue_random(100, 0, 0, 7);

        // phase 2: full capacity, sender idle, with one complete pause midway
        set_active(4'd8);
        send_idle_pct  = 64;
        recv_stall_pct = 0;
        queue_random(60, 0, 0, 7);
        drain();
        queue_random(60, 0, 0, 7);

        // phase 3: partial count, loads land in inactive slots, receiver stalls
        set_active(4'd5);
        send_idle_pct  = 0;
        recv_stall_pct = 64;
        queue_random(120, 10, 5, 7);

        // phase 4: single slot, both sides idle
        set_active(4'd1);
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        queue_random(80, 10, 1, 7);

        // phase 5: nothing active, loads anywhere, every tick idle
        set_active(4'd0);
        queue_random(80, 15, 0, 7);

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("run covered %0d load items and %0d tick items over five active counts",
                 n_loads, n_ticks);
        $display("reports checked: %0d busy, %0d idle", n_busy, n_idle);
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // hang guard, far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
